### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable priority queue
// Operation codes, error codes and the control word that is broadcast to
// every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int OP_BITS  = 2;
	localparam int ERR_BITS = 2;

	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

	localparam logic [ERR_BITS-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_BITS-1:0] ERR_EMPTY = 2'd1;
	localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd2;

	// broadcast to all cells; at most one is high
	typedef struct packed {
		logic ins;	// legal insert accepted this cycle
		logic rem;	// legal removal accepted this cycle
	} cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry. On insert it keeps, takes the new entry or takes its
// upper neighbor; on removal it takes its lower neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
	import spq_pkg::*;
#(
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 16
) (
	input  wire                             clk,
	input  wire cell_ctrl_t                 ctrl,
	input  wire                             occupied,	// slot below held count
	input  wire logic signed [PRIORITY_BITS-1:0] new_pri,
	input  wire logic [PAYLOAD_BITS-1:0]    new_pay,
	input  wire                             up_keep,	// upper neighbor keeps its entry
	input  wire logic signed [PRIORITY_BITS-1:0] up_pri,
	input  wire logic [PAYLOAD_BITS-1:0]    up_pay,
	input  wire logic signed [PRIORITY_BITS-1:0] dn_pri,
	input  wire logic [PAYLOAD_BITS-1:0]    dn_pay,
	output logic                            keep,
	output logic signed [PRIORITY_BITS-1:0] pri,
	output logic [PAYLOAD_BITS-1:0]         pay,
	output logic signed [PRIORITY_BITS-1:0] pri_d,
	output logic [PAYLOAD_BITS-1:0]         pay_d
);

	logic signed [PRIORITY_BITS-1:0] pri_q;
	logic [PAYLOAD_BITS-1:0]         pay_q;

	// >= keeps equal priorities ahead of the newcomer (FIFO among equals)
	assign keep = occupied && (pri_q >= new_pri);
	assign pri  = pri_q;
	assign pay  = pay_q;

	always_comb begin
		pri_d = pri_q;
		pay_d = pay_q;
		if (ctrl.ins && !keep) begin
			if (up_keep) begin
				pri_d = new_pri;
				pay_d = new_pay;
			end else begin
				pri_d = up_pri;
				pay_d = up_pay;
			end
		end else if (ctrl.rem) begin
			pri_d = dn_pri;
			pay_d = dn_pay;
		end
	end

	always_ff @(posedge clk) begin
		pri_q <= pri_d;
		pay_q <= pay_d;
	end

endmodule

`default_nettype wire

### rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted-list priority queue
// Row of CAPACITY cells kept in descending priority, FIFO among equals.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream (s_*) carries one command item per handshake: insert an
//    entry, remove the head, or clear. Master stream (m_*) returns exactly
//    one result item per command: head entry, count, empty flag, error.
//  - All cells compare the broadcast priority in parallel and shift by one
//    position in the same cycle.
//  - Latency: result is valid the cycle after the command is accepted.
//  - Throughput: one item per cycle while the receiver takes results.
//    The single output register sets the figure: a new command is accepted
//    when that register is empty or is being read in the same cycle.
//  - Receiver stall: the result holds in m_tdata, s_tready drops, and the
//    queue contents do not change until the result is taken.
//  - Reset: held count cleared, output register empty. Slot contents are
//    not cleared; slots at or above the held count are never looked at.
//  - Insert into a full queue or removal from an empty one changes nothing
//    and reports an error code. Unused op codes change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY      = 16,
	parameter int PAYLOAD_BITS  = 32,
	parameter int PRIORITY_BITS = 16
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	// op, priority_req, payload (low bits up), zero fill to bytes
	input  wire  [((OP_BITS+PRIORITY_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  wire  m_tready,
	// head_payload, head_priority, entry_count, is_empty, error_code
	// (low bits up), zero fill to bytes
	output logic [((PAYLOAD_BITS+PRIORITY_BITS+$clog2(CAPACITY+1)+1+ERR_BITS+7)/8)*8-1:0]
		m_tdata
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int IN_USED  = OP_BITS + PRIORITY_BITS + PAYLOAD_BITS;
	localparam int OUT_USED = PAYLOAD_BITS + PRIORITY_BITS + CNT_BITS + 1 + ERR_BITS;
	localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

	// ---- input unpack ----
	logic [OP_BITS-1:0]              op;
	logic signed [PRIORITY_BITS-1:0] priority_req;
	logic [PAYLOAD_BITS-1:0]         payload;

	assign op           = s_tdata[OP_BITS-1:0];
	assign priority_req = s_tdata[OP_BITS+PRIORITY_BITS-1:OP_BITS];
	assign payload      = s_tdata[IN_USED-1:OP_BITS+PRIORITY_BITS];

	// ---- control ----
	logic [CNT_BITS-1:0] count_q, count_d;
	logic                out_valid_q;
	logic                accept, full, empty;
	logic [ERR_BITS-1:0] err;
	cell_ctrl_t          ctrl;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_BITS'(CAPACITY));
	assign empty    = (count_q == '0);

	always_comb begin
		ctrl    = '0;
		err     = ERR_NONE;
		count_d = count_q;
		case (op)
			OP_INSERT: begin
				if (full) begin
					err = ERR_FULL;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + CNT_BITS'(1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					err = ERR_EMPTY;
				end else begin
					ctrl.rem = accept;
					count_d  = count_q - CNT_BITS'(1);
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// ---- cell row ----
	logic                            keep  [CAPACITY];
	logic signed [PRIORITY_BITS-1:0] pri   [CAPACITY];
	logic [PAYLOAD_BITS-1:0]         pay   [CAPACITY];
	logic signed [PRIORITY_BITS-1:0] pri_d [CAPACITY];
	logic [PAYLOAD_BITS-1:0]         pay_d [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                            up_keep;
		logic signed [PRIORITY_BITS-1:0] up_pri, dn_pri;
		logic [PAYLOAD_BITS-1:0]         up_pay, dn_pay;

		if (i == 0) begin : g_top
			// head cell: nothing above, so on insert it takes the new entry if it moves
			assign up_keep = 1'b1;
			assign up_pri  = priority_req;
			assign up_pay  = payload;
		end else begin : g_mid
			assign up_keep = keep[i-1];
			assign up_pri  = pri[i-1];
			assign up_pay  = pay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_bot
			assign dn_pri = '0;
			assign dn_pay = '0;
		end else begin : g_up
			assign dn_pri = pri[i+1];
			assign dn_pay = pay[i+1];
		end

		spq_cell #(
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.PRIORITY_BITS(PRIORITY_BITS)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.occupied(count_q > CNT_BITS'(i)),
			.new_pri (priority_req),
			.new_pay (payload),
			.up_keep (up_keep),
			.up_pri  (up_pri),
			.up_pay  (up_pay),
			.dn_pri  (dn_pri),
			.dn_pay  (dn_pay),
			.keep    (keep[i]),
			.pri     (pri[i]),
			.pay     (pay[i]),
			.pri_d   (pri_d[i]),
			.pay_d   (pay_d[i])
		);
	end

	// ---- state and result register ----
	logic                            res_empty;
	logic [OUT_W-1:0]                res_q;

	assign res_empty = (count_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// zero fill above the used bits comes from the size cast
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= OUT_W'({err,
				res_empty,
				count_d,
				res_empty ? {PRIORITY_BITS{1'b0}} : pri_d[0],
				res_empty ? {PAYLOAD_BITS{1'b0}} : pay_d[0]});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

endmodule

`default_nettype wire

### tb/tb_stable_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: self-checking bench for the stable priority queue
// Streams insert, remove, clear and unused commands into the block and checks
// every result item against a sorted-list predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stable_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int PAY_W          = 32;
	localparam int PRI_W          = 16;
	localparam int CNT_W          = $clog2(DEPTH + 1);
	localparam int IN_W           = ((OP_BITS + PRI_W + PAY_W + 7) / 8) * 8;
	localparam int OUT_W          = ((PAY_W + PRI_W + CNT_W + 1 + ERR_BITS + 7) / 8) * 8;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int REPORT_LIMIT   = 10;

	// op code the block has no use for; it must leave the queue alone
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_BITS-1:0]      op;
		logic signed [PRI_W-1:0] pri;
		logic [PAY_W-1:0]        pay;
		bit                      settle;	// sender waits for all results first
	} cmd_t;

	typedef struct {
		logic [PAY_W-1:0]        head_pay;
		logic signed [PRI_W-1:0] head_pri;
		logic [CNT_W-1:0]        count;
		logic                    empty;
		logic [ERR_BITS-1:0]     err;
	} res_t;

	logic            clk;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata  = '0;	// op, priority_req, payload (low bits up)
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	// head_payload, head_priority, entry_count, is_empty, error_code (low bits up)
	logic [OUT_W-1:0] m_tdata;

	stable_priority_queue #(
		.CAPACITY     (DEPTH),
		.PAYLOAD_BITS (PAY_W),
		.PRIORITY_BITS(PRI_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	cmd_t pending_cmds[$];	// commands waiting for the driver
	res_t expected_heads[$];	// predicted results, oldest first

	// predictor copy of the sorted row
	logic [PAY_W-1:0]        row_pay[DEPTH];
	logic signed [PRI_W-1:0] row_pri[DEPTH];
	int                      row_count = 0;

	int cmds_offered  = 0;
	int cmds_taken    = 0;
	int results_taken = 0;
	int mismatches    = 0;
	int op_seen[4]    = '{0, 0, 0, 0};
	int full_rejects  = 0;
	int empty_rejects = 0;
	int holds_done    = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor: applies one command to the sorted row and returns the
	// result the block must report afterwards.
	// ------------------------------------------------------------------
	function automatic res_t queue_apply(cmd_t c);
		res_t r;
		int   pos;
		r.err = ERR_NONE;
		op_seen[c.op]++;
		case (c.op)
			OP_INSERT: begin
				if (row_count >= DEPTH) begin
					r.err = ERR_FULL;
					full_rejects++;
				end else begin
					// first cell strictly lower goes down; equals stay ahead (FIFO)
					pos = 0;
					while (pos < row_count && row_pri[pos] >= c.pri)
						pos++;
					for (int k = row_count; k > pos; k--) begin
						row_pay[k] = row_pay[k-1];
						row_pri[k] = row_pri[k-1];
					end
					row_pay[pos] = c.pay;
					row_pri[pos] = c.pri;
					row_count++;
				end
			end
			OP_REMOVE: begin
				if (row_count == 0) begin
					r.err = ERR_EMPTY;
					empty_rejects++;
				end else begin
					for (int k = 0; k + 1 < row_count; k++) begin
						row_pay[k] = row_pay[k+1];
						row_pri[k] = row_pri[k+1];
					end
					row_count--;
				end
			end
			OP_CLEAR: begin
				row_count = 0;
			end
			default: ;
		endcase
		r.count = CNT_W'(row_count);
		r.empty = (row_count == 0);
		r.head_pay = (row_count > 0) ? row_pay[0] : '0;
		r.head_pri = (row_count > 0) ? row_pri[0] : '0;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [OP_BITS-1:0] op, int pri, logic [PAY_W-1:0] pay);
		cmd_t c;
		c.op = op;
		c.pri = PRI_W'(pri);
		c.pay = pay;
		c.settle = 1'b0;
		return c;
	endfunction

	task automatic check_head(res_t got);
		res_t want;
		if (expected_heads.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] result item with no command outstanding: %p", $realtime, got);
			return;
		end
		want = expected_heads.pop_front();
		if (got.head_pay !== want.head_pay || got.head_pri !== want.head_pri ||
				got.count !== want.count || got.empty !== want.empty ||
				got.err !== want.err) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("[%0t] result %0d wrong", $realtime, results_taken);
				$display("  want pay=%h pri=%0d cnt=%0d empty=%b err=%0d",
					want.head_pay, want.head_pri, want.count, want.empty, want.err);
				$display("  got  pay=%h pri=%0d cnt=%0d empty=%b err=%0d",
					got.head_pay, got.head_pri, got.count, got.empty, got.err);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: both handshakes are sampled at the rising edge. The result
	// check runs before the new prediction; the result is registered, so
	// the result seen now never belongs to the command taken at this edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_head('{head_pay: m_tdata[PAY_W-1:0],
					head_pri: m_tdata[PAY_W+PRI_W-1:PAY_W],
					count:    m_tdata[PAY_W+PRI_W+CNT_W-1:PAY_W+PRI_W],
					empty:    m_tdata[PAY_W+PRI_W+CNT_W],
					err:      m_tdata[PAY_W+PRI_W+CNT_W+ERR_BITS:PAY_W+PRI_W+CNT_W+1]});
				results_taken++;
			end
			if (s_tvalid && s_tready) begin
				expected_heads.push_back(queue_apply(make_cmd(s_tdata[OP_BITS-1:0],
					$signed(s_tdata[OP_BITS+PRI_W-1:OP_BITS]),
					s_tdata[OP_BITS+PRI_W+PAY_W-1:OP_BITS+PRI_W])));
				cmds_taken++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts of random length with random gaps. An item marked
	// settle is held back until every predicted result has come out.
	// ------------------------------------------------------------------
	int burst_left = 8;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && cmds_taken != cmds_offered) begin
			// current item not yet taken: hold it
		end else if (gap_left > 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (pending_cmds.size() == 0 ||
				(pending_cmds[0].settle && expected_heads.size() != 0)) begin
			s_tvalid <= 1'b0;
		end else begin
			cmd_t c;
			c = pending_cmds.pop_front();
			s_tdata <= {{(IN_W - OP_BITS - PRI_W - PAY_W){1'b0}}, c.pay, c.pri, c.op};
			s_tvalid <= 1'b1;
			cmds_offered++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: a random ready pattern reloaded now and then (sometimes
	// always ready), plus a long hold-off at 600 results, then every 900,
	// so the output register stays full and s_tready drops for a while.
	// ------------------------------------------------------------------
	logic [31:0] ready_pat  = '1;
	int          pat_left   = 0;
	int          pat_pos    = 0;
	int          hold_left  = 0;
	int          next_hold  = 600;

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (results_taken >= next_hold) begin
			hold_left = HOLD_CYCLES - 1;
			next_hold += 900;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(20, 80);
				case ($urandom_range(0, 3))
					0:       ready_pat = '1;
					1:       ready_pat = $urandom() | $urandom();
					2:       ready_pat = $urandom() & $urandom();
					default: ready_pat = $urandom();
				endcase
			end
			pat_left--;
			pat_pos = (pat_pos + 1) % 32;
			m_tready <= ready_pat[pat_pos];
		end
	end

	// watchdog: cycles with no handshake on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		cmd_t c;
		int   seg_len;
		int   style;
		int   pick;
		int   lo_pri;

		// empty queue: remove, clear and the unused code
		pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 32'h0));
		pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 32'h0));
		pending_cmds.push_back(make_cmd(OP_UNUSED, -1, 32'hFFFF_FFFF));
		// field extremes and a tie at the top priority
		pending_cmds.push_back(make_cmd(OP_INSERT, 32767, 32'hFFFF_FFFF));
		pending_cmds.push_back(make_cmd(OP_INSERT, -32768, 32'h0000_0000));
		pending_cmds.push_back(make_cmd(OP_INSERT, 32767, 32'h0000_0001));
		pending_cmds.push_back(make_cmd(OP_INSERT, 0, 32'hA5A5_5A5A));
		pending_cmds.push_back(make_cmd(OP_UNUSED, 5, 32'h1234_5678));
		pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 32'h0));
		pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 32'h0));
		// fill up with heavy ties, then knock on the full queue
		for (int i = 0; i < DEPTH - 2; i++)
			pending_cmds.push_back(make_cmd(OP_INSERT, (i % 3) - 1, 32'h100 + i));
		pending_cmds.push_back(make_cmd(OP_INSERT, 32767, 32'hDEAD_BEEF));
		pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 32'h0));

		// random segments, each leaning toward filling, draining or mixing
		for (int n = 0; n < RANDOM_ITEMS; ) begin
			seg_len = $urandom_range(10, 60);
			style = $urandom_range(0, 3);
			lo_pri = $urandom_range(0, 65535) - 32768;
			for (int j = 0; j < seg_len; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					c.op = OP_CLEAR;
				else if (pick < 4)
					c.op = OP_UNUSED;
				else if (style == 0)
					c.op = (pick < 75) ? OP_INSERT : OP_REMOVE;
				else if (style == 1)
					c.op = (pick < 30) ? OP_INSERT : OP_REMOVE;
				else
					c.op = (pick < 52) ? OP_INSERT : OP_REMOVE;
				// in styles 0 to 2 half the items use a narrow band so ties are common
				if (style == 3 || $urandom_range(0, 1) == 0)
					c.pri = PRI_W'($urandom_range(0, 65535));
				else
					c.pri = PRI_W'(lo_pri + $urandom_range(0, 3));
				c.pay = $urandom();
				// sender waits for the block to go quiet a few times per run
				c.settle = (n > 0 && n % 500 == 0);
				pending_cmds.push_back(c);
				if (c.op != OP_UNUSED)
					n++;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || cmds_taken != cmds_offered ||
				expected_heads.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_heads.size() != 0 || m_tvalid)
			mismatches++;

		$display("covered %0d commands (insert %0d, remove %0d, clear %0d, unused %0d), %0d results",
			cmds_taken, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_CLEAR],
			op_seen[OP_UNUSED], results_taken);
		$display("full-queue rejects %0d, empty removals %0d, long receiver hold-offs %0d",
			full_rejects, empty_rejects, holds_done);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
